@@ sv/srte_pkg.sv @@
// Shared types and constants for the shaper rate table entry unit.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package srte_pkg;

    localparam int CFG_W                = 32;
    localparam int SIZE_W               = 32;
    localparam int TICKS_W              = 32;
    localparam int CELL_LOG_W           = 5;
    localparam int CELL_LOG_SET_W       = 6;
    localparam int FRAC_W               = 16;
    localparam int AUTO_LIMIT_W         = 8;      // auto limit 255 is 8 bits of ones
    localparam int USEC_PER_SEC_DEFAULT = 1000000;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [CELL_LOG_W-1:0] CELL_LOG_MAX = 5'd23;
    localparam logic [15:0]           MTU_DEFAULT  = 16'd2047;

    typedef enum logic [2:0] {
        REG_RATE         = 3'd0,
        REG_CELL_LOG     = 3'd1,
        REG_MTU          = 3'd2,
        REG_MIN_PKT      = 3'd3,
        REG_OVERHEAD     = 3'd4,
        REG_TICK_FACTOR  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [31:0]               rate;
        logic [CELL_LOG_SET_W-1:0] cell_log_setting;
        logic [15:0]               mtu;
        logic [7:0]                min_pkt;
        logic [7:0]                overhead;
        logic [31:0]               tick_factor;
    } cfg_t;

    typedef struct packed {
        logic [CELL_LOG_W-1:0] cell_shift;
        logic                  rate_zero;
    } tag_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        tag_t              tag;
    } item_t;

endpackage

@@ sv/srte_front.sv @@
// Front end: accepts a table index, picks the cell log and forms the packet size.
// Depends on srte_pkg.
`timescale 1ns / 1ps

module srte_front
(
    input  logic               start,
    input  logic [7:0]         table_index,
    input  srte_pkg::cfg_t     cfg,
    input  logic               queue_full,
    output logic               push,
    output srte_pkg::item_t    item
);

    logic [srte_pkg::CELL_LOG_W-1:0] cell_shift;
    logic [srte_pkg::SIZE_W-1:0]     size;

    // cell log: fixed setting clamped to max, or auto from mtu bit length
    always_comb
    begin
        logic [15:0] mtu_eff;
        logic [4:0]  bit_len;
        mtu_eff = (cfg.mtu == 16'd0) ? srte_pkg::MTU_DEFAULT : cfg.mtu;
        bit_len = 5'd0;
        for (int b = 0; b < 16; b++)
        begin
            if (mtu_eff[b])
            begin
                bit_len = 5'(b + 1);
            end
        end
        if (cfg.cell_log_setting[srte_pkg::CELL_LOG_SET_W-1])
        begin
            if (bit_len > 5'(srte_pkg::AUTO_LIMIT_W))
            begin
                cell_shift = bit_len - 5'(srte_pkg::AUTO_LIMIT_W);
            end
            else
            begin
                cell_shift = '0;
            end
        end
        else if (cfg.cell_log_setting[4:0] > srte_pkg::CELL_LOG_MAX)
        begin
            cell_shift = srte_pkg::CELL_LOG_MAX;
        end
        else
        begin
            cell_shift = cfg.cell_log_setting[4:0];
        end
    end

    // index wraps modulo the 256-entry table, which an 8-bit index already does
    always_comb
    begin
        logic [srte_pkg::SIZE_W-1:0] raw;
        raw = (srte_pkg::SIZE_W'(table_index) << cell_shift)
            + srte_pkg::SIZE_W'(cfg.overhead);
        if (raw < srte_pkg::SIZE_W'(cfg.min_pkt))
        begin
            size = srte_pkg::SIZE_W'(cfg.min_pkt);
        end
        else
        begin
            size = raw;
        end
    end

    assign push                = start & ~queue_full;
    assign item.size           = size;
    assign item.tag.cell_shift = cell_shift;
    assign item.tag.rate_zero  = (cfg.rate == 32'd0);

endmodule

@@ sv/srte_queue.sv @@
// Short request queue between the front end and the arithmetic back end.
// Depends on srte_pkg.
`timescale 1ns / 1ps

module srte_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  srte_pkg::item_t push_item,
    input  logic            pop,
    output logic            not_empty,
    output logic            full,
    output srte_pkg::item_t pop_item
);

    localparam int DEPTH = srte_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    srte_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ sv/srte_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, one request per cycle.
// Depends on srte_pkg.
`timescale 1ns / 1ps

module srte_div_pipe
#(
    parameter int NUM_W = 52
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  srte_pkg::tag_t   in_tag,
    input  logic [31:0]      divisor,
    output logic             out_valid,
    output logic [NUM_W-1:0] out_quo,
    output srte_pkg::tag_t   out_tag
);

    localparam int DEN_W = 32;

    logic             valid_reg [NUM_W];
    logic [NUM_W-1:0] num_reg   [NUM_W];
    logic [DEN_W-1:0] rem_reg   [NUM_W];
    srte_pkg::tag_t   tag_reg   [NUM_W];

    genvar k;
    for (k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             v_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] rem_in;
        srte_pkg::tag_t   tag_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             fits;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign num_in = in_num;
            assign rem_in = '0;
            assign tag_in = in_tag;
        end
        else
        begin : g_next
            assign v_in   = valid_reg[k-1];
            assign num_in = num_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign tag_in = tag_reg[k-1];
        end

        // numerator shifts out at the top while quotient bits enter at the bottom
        assign trial = {rem_in, num_in[NUM_W-1]};
        assign diff  = trial - {1'b0, divisor};
        assign fits  = (trial >= {1'b0, divisor});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[k] <= {num_in[NUM_W-2:0], fits};
            rem_reg[k] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            tag_reg[k] <= tag_in;
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo   = num_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

@@ sv/srte_back.sv @@
// Back end: size to microseconds (multiply, divide), then to ticks and saturate.
// Depends on srte_pkg and srte_div_pipe.
`timescale 1ns / 1ps

module srte_back
#(
    parameter int USEC_PER_SEC = srte_pkg::USEC_PER_SEC_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  srte_pkg::item_t                  q_item,
    input  srte_pkg::cfg_t                   cfg,
    output logic                             pop,
    output logic                             done,
    output logic [srte_pkg::TICKS_W-1:0]     xmit_ticks,
    output logic [srte_pkg::CELL_LOG_W-1:0]  cell_log_used,
    output logic                             saturated
);

    localparam int USEC_W = $clog2(USEC_PER_SEC + 1);
    localparam int NUM_W  = srte_pkg::SIZE_W + USEC_W;
    localparam int QH_W   = NUM_W - 32;
    localparam int PH_W   = QH_W + 32;
    localparam int FR     = srte_pkg::FRAC_W;
    localparam int SUM_W  = 64 - FR + 1;

    localparam logic [USEC_W-1:0] USEC_K = USEC_W'(USEC_PER_SEC);

    // stage M0: numerator
    logic             m0_valid_reg;
    logic [NUM_W-1:0] m0_num_reg;
    srte_pkg::tag_t   m0_tag_reg;

    // divider output
    logic             dv_valid;
    logic [NUM_W-1:0] dv_quo;
    srte_pkg::tag_t   dv_tag;

    // stage M1: low partial product
    logic             m1_valid_reg;
    logic [63:0]      m1_plo_reg;
    logic [QH_W-1:0]  m1_qhi_reg;
    srte_pkg::tag_t   m1_tag_reg;

    // stage M2: high partial product
    logic             m2_valid_reg;
    logic [63:0]      m2_plo_reg;
    logic [PH_W-1:0]  m2_phi_reg;
    srte_pkg::tag_t   m2_tag_reg;

    // output stage
    logic                            done_reg;
    logic [srte_pkg::TICKS_W-1:0]    ticks_reg, ticks_next;
    logic [srte_pkg::CELL_LOG_W-1:0] cell_shift_reg;
    logic                            sat_reg, sat_next;

    assign pop = q_valid;

    srte_div_pipe #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m0_valid_reg),
        .in_num    (m0_num_reg),
        .in_tag    (m0_tag_reg),
        .divisor   (cfg.rate),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // final fold: ticks = (p_hi << 16) + (p_lo >> 16), saturated to 32 bits; zero rate also saturates
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        sum = SUM_W'({m2_phi_reg[FR-1:0], {FR{1'b0}}}) + SUM_W'(m2_plo_reg[63:FR]);
        if (m2_tag_reg.rate_zero)
        begin
            ticks_next = '1;
            sat_next   = 1'b1;
        end
        else if (m2_phi_reg[PH_W-1:FR] != '0)
        begin
            ticks_next = '1;
            sat_next   = 1'b1;
        end
        else if (sum[SUM_W-1:srte_pkg::TICKS_W] != '0)
        begin
            ticks_next = '1;
            sat_next   = 1'b1;
        end
        else
        begin
            ticks_next = sum[srte_pkg::TICKS_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_valid_reg <= 1'b0;
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            m0_valid_reg <= q_valid;
            m1_valid_reg <= dv_valid;
            m2_valid_reg <= m1_valid_reg;
            done_reg     <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_num_reg     <= {{USEC_W{1'b0}}, q_item.size} * {{srte_pkg::SIZE_W{1'b0}}, USEC_K};
        m0_tag_reg     <= q_item.tag;
        m1_plo_reg     <= {32'd0, dv_quo[31:0]} * {32'd0, cfg.tick_factor};
        m1_qhi_reg     <= dv_quo[NUM_W-1:32];
        m1_tag_reg     <= dv_tag;
        m2_phi_reg     <= PH_W'(m1_qhi_reg) * PH_W'(cfg.tick_factor);
        m2_plo_reg     <= m1_plo_reg;
        m2_tag_reg     <= m1_tag_reg;
        ticks_reg      <= ticks_next;
        sat_reg        <= sat_next;
        cell_shift_reg <= m2_tag_reg.cell_shift;
    end

    assign done          = done_reg;
    assign xmit_ticks    = ticks_reg;
    assign cell_log_used = cell_shift_reg;
    assign saturated     = sat_reg;

endmodule

@@ sv/shaper_rate_table_entry_unit.sv @@
// Top level of the shaper rate table entry unit: config registers and the
// front end / request queue / arithmetic back end. Depends on srte_pkg,
// srte_front, srte_queue and srte_back.
//
// Usage
//   Requests: drive table_index and raise start; a request is taken at each
//   rising edge with start high and busy low. busy only rises if the queue
//   fills, which the free-running back end never lets happen, so one
//   request per cycle is sustained.
//   Results: done is high for exactly one cycle with xmit_ticks,
//   cell_log_used and saturated. The receiver cannot stall; results come
//   out in request order.
//   Result path: an accepted request passes the queue, the size multiplier,
//   the bit-per-stage divider that turns bytes into microseconds (NUM_W =
//   32 + bits(USEC_PER_SEC) bits wide), two partial products for the
//   Q16.16 tick scale and the output register.
//   Config: write cfg_write_en/cfg_index/cfg_data while no request is in
//   flight; registers are read live by both ends. Unknown indexes are
//   ignored.
//   Reset: rst_n (async, active low) empties the queue and pipeline and
//   loads rate 1, automatic cell log, mtu 0, min size 0, overhead 0 and
//   tick factor 1.0.
`timescale 1ns / 1ps

module shaper_rate_table_entry_unit
#(
    parameter int USEC_PER_SEC = srte_pkg::USEC_PER_SEC_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       table_index,
    // config write port
    input  logic                             cfg_write_en,
    input  logic [2:0]                       cfg_index,
    input  logic [srte_pkg::CFG_W-1:0]       cfg_data,
    // result channel
    output logic                             done,
    output logic [srte_pkg::TICKS_W-1:0]     xmit_ticks,
    output logic [srte_pkg::CELL_LOG_W-1:0]  cell_log_used,
    output logic                             saturated
);

    srte_pkg::cfg_t  cfg_reg;
    srte_pkg::item_t front_item;
    srte_pkg::item_t queue_item;
    logic            front_push;
    logic            queue_full;
    logic            queue_not_empty;
    logic            back_pop;

    // config registers; cell log setting resets to -1 (automatic)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate             <= 32'd1;
            cfg_reg.cell_log_setting <= '1;
            cfg_reg.mtu              <= 16'd0;
            cfg_reg.min_pkt          <= 8'd0;
            cfg_reg.overhead         <= 8'd0;
            cfg_reg.tick_factor      <= 32'd1 << srte_pkg::FRAC_W;
        end
        else if (cfg_write_en)
        begin
            case (srte_pkg::cfg_index_t'(cfg_index))
                srte_pkg::REG_RATE:
                begin
                    cfg_reg.rate <= cfg_data[31:0];
                end
                srte_pkg::REG_CELL_LOG:
                begin
                    cfg_reg.cell_log_setting <= cfg_data[srte_pkg::CELL_LOG_SET_W-1:0];
                end
                srte_pkg::REG_MTU:
                begin
                    cfg_reg.mtu <= cfg_data[15:0];
                end
                srte_pkg::REG_MIN_PKT:
                begin
                    cfg_reg.min_pkt <= cfg_data[7:0];
                end
                srte_pkg::REG_OVERHEAD:
                begin
                    cfg_reg.overhead <= cfg_data[7:0];
                end
                srte_pkg::REG_TICK_FACTOR:
                begin
                    cfg_reg.tick_factor <= cfg_data[31:0];
                end
                default:
                begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    srte_front u_front (
        .start       (start),
        .table_index (table_index),
        .cfg         (cfg_reg),
        .queue_full  (queue_full),
        .push        (front_push),
        .item        (front_item)
    );

    srte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .pop       (back_pop),
        .not_empty (queue_not_empty),
        .full      (queue_full),
        .pop_item  (queue_item)
    );

    srte_back #(
        .USEC_PER_SEC (USEC_PER_SEC)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (queue_not_empty),
        .q_item        (queue_item),
        .cfg           (cfg_reg),
        .pop           (back_pop),
        .done          (done),
        .xmit_ticks    (xmit_ticks),
        .cell_log_used (cell_log_used),
        .saturated     (saturated)
    );

    // request is refused only while the queue is full
    assign busy = queue_full;

endmodule

@@ tb/shaper_rate_table_entry_unit_test.sv @@
// Testbench for shaper_rate_table_entry_unit: directed corner cases, then random
// config phases with random idle gaps; results are checked against an in-bench predictor.
// Depends on srte_pkg and shaper_rate_table_entry_unit.
`timescale 1ns / 1ps

module shaper_rate_table_entry_unit_test;

    // delay from the accepting edge to done at the default rate scale
    localparam int RESULT_LATENCY = 56;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RANDOM_PHASES  = 12;

    // Register indexes with no register behind them; writes must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                            clk;
    logic                            rst_n        = 1'b0;
    logic                            start        = 1'b0;
    logic [7:0]                      table_index  = '0;
    logic                            cfg_write_en = 1'b0;
    logic [2:0]                      cfg_index    = '0;
    logic [srte_pkg::CFG_W-1:0]      cfg_data     = '0;
    logic                            busy;
    logic                            done;
    logic [srte_pkg::TICKS_W-1:0]    xmit_ticks;
    logic [srte_pkg::CELL_LOG_W-1:0] cell_log_used;
    logic                            saturated;

    int unsigned cycle_count = 0;

    typedef struct {
        logic [srte_pkg::TICKS_W-1:0]    ticks;
        logic [srte_pkg::CELL_LOG_W-1:0] cell_shift;
        logic                            sat;
    } tick_entry_t;

    // Mirror of the config registers plus the queue of predicted table entries.
    class tick_table_checker;
        logic [31:0]                         rate;
        logic [srte_pkg::CELL_LOG_SET_W-1:0] shift_set;
        logic [15:0]                         mtu;
        logic [7:0]                          min_pkt;
        logic [7:0]                          overhead;
        logic [31:0]                         tick_factor;
        tick_entry_t                         expected_entries[$];
        int                                  mismatches;

        function new();
            rate         = 32'd1;
            shift_set    = '1;
            mtu          = '0;
            min_pkt      = '0;
            overhead     = '0;
            tick_factor  = 32'h0001_0000;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                srte_pkg::REG_RATE:        rate        = data;
                srte_pkg::REG_CELL_LOG:    shift_set   = data[srte_pkg::CELL_LOG_SET_W-1:0];
                srte_pkg::REG_MTU:         mtu         = data[15:0];
                srte_pkg::REG_MIN_PKT:     min_pkt     = data[7:0];
                srte_pkg::REG_OVERHEAD:    overhead    = data[7:0];
                srte_pkg::REG_TICK_FACTOR: tick_factor = data;
                default:                   ;
            endcase
        endfunction

        function int pending();
            return expected_entries.size();
        endfunction

        // Works out the table entry for an accepted request.
        function void note_request(logic [7:0] idx);
            tick_entry_t  e;
            logic [15:0]  mtu_eff;
            logic [63:0]  pkt_size;
            logic [63:0]  usec;
            logic [127:0] scaled;
            e.cell_shift = '0;
            if (!shift_set[srte_pkg::CELL_LOG_SET_W-1]) begin
                if (shift_set > 6'(srte_pkg::CELL_LOG_MAX))
                    e.cell_shift = srte_pkg::CELL_LOG_MAX;
                else
                    e.cell_shift = shift_set[srte_pkg::CELL_LOG_W-1:0];
            end
            else begin
                // auto: smallest shift that brings the mtu down to 255
                mtu_eff = (mtu == 16'd0) ? srte_pkg::MTU_DEFAULT : mtu;
                while ((mtu_eff >> e.cell_shift) > 16'd255)
                    e.cell_shift = e.cell_shift + 5'd1;
            end
            pkt_size = (64'(idx) << e.cell_shift) + 64'(overhead);
            if (pkt_size < 64'(min_pkt))
                pkt_size = 64'(min_pkt);
            if (rate == 32'd0) begin
                e.ticks = '1;
                e.sat   = 1'b1;
            end
            else begin
                usec   = (64'(srte_pkg::USEC_PER_SEC_DEFAULT) * pkt_size) / 64'(rate);
                scaled = (128'(usec) * 128'(tick_factor)) >> srte_pkg::FRAC_W;
                if (scaled > 128'hFFFF_FFFF) begin
                    e.ticks = '1;
                    e.sat   = 1'b1;
                end
                else begin
                    e.ticks = scaled[srte_pkg::TICKS_W-1:0];
                    e.sat   = 1'b0;
                end
            end
            expected_entries.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h",
                         $realtime, what, got, want);
        endtask

        task check_result(logic [srte_pkg::TICKS_W-1:0] ticks,
                          logic [srte_pkg::CELL_LOG_W-1:0] cl, logic sat);
            tick_entry_t e;
            if (expected_entries.size() == 0) begin
                report("result with no request pending", ticks, '0);
                return;
            end
            e = expected_entries.pop_front();
            if (ticks !== e.ticks)
                report("xmit_ticks", ticks, e.ticks);
            if (cl !== e.cell_shift)
                report("cell_log_used", 32'(cl), 32'(e.cell_shift));
            if (sat !== e.sat)
                report("saturated", 32'(sat), 32'(e.sat));
        endtask
    endclass

    tick_table_checker entry_check = new();

    shaper_rate_table_entry_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .table_index   (table_index),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .done          (done),
        .xmit_ticks    (xmit_ticks),
        .cell_log_used (cell_log_used),
        .saturated     (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Results cannot be held off: every done cycle is checked at the edge that ends it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            entry_check.check_result(xmit_ticks, cell_log_used, saturated);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Holds the request until the edge that takes it; start stays high for the caller.
    task automatic send_request(input logic [7:0] idx);
        start       <= 1'b1;
        table_index <= idx;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        entry_check.note_request(idx);
    endtask

    // Stop sending and let every outstanding request come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (entry_check.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Leaves write enable high; close_writes drops it after the last one.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        entry_check.set_reg(idx, data);
    endtask

    task automatic close_writes();
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // Random setting for all six registers, biased toward the extremes.
    task automatic random_config();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'd0;
            1:       v = 32'd1;
            2:       v = 32'hFFFF_FFFF;
            3, 4:    v = $urandom_range(2000, 1);
            5, 6:    v = $urandom_range(100_000_000, 1000);
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_RATE, v);
        // junk above the 6-bit field must be dropped
        case ($urandom_range(4))
            0:       v = 32'h3F;
            1:       v = $urandom_range(23, 0);
            2:       v = $urandom_range(31, 24);
            3:       v = $urandom_range(63, 32);
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_CELL_LOG, v);
        case ($urandom_range(3))
            0:       v = 32'd0;
            1:       v = 32'hFFFF;
            2:       v = $urandom_range(600, 0);
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_MTU, v);
        case ($urandom_range(3))
            0:       v = 32'd0;
            1:       v = 32'hFF;
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_MIN_PKT, v);
        case ($urandom_range(3))
            0:       v = 32'd0;
            1:       v = 32'hFF;
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_OVERHEAD, v);
        case ($urandom_range(7))
            0:       v = 32'd0;
            1:       v = 32'h0001_0000;
            2:       v = 32'hFFFF_FFFF;
            3, 4:    v = $urandom_range(32'h0003_0000, 0);
            default: v = $urandom;
        endcase
        write_reg(srte_pkg::REG_TICK_FACTOR, v);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        close_writes();
    endtask

    initial
    begin
        int idle_pct;
        int count;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset settings: rate 1, auto cell log from the default mtu, tick factor 1.0
        send_request(8'd0);
        send_request(8'd255);
        send_request(8'd1);
        send_request(8'd170);
        wait_drained();

        // zero rate saturates regardless of size
        write_reg(srte_pkg::REG_RATE, 32'd0);
        close_writes();
        send_request(8'd0);
        send_request(8'd85);
        wait_drained();

        // rate, cell log, overhead, min size and tick factor at their top values; index 255 overflows the tick count
        write_reg(srte_pkg::REG_RATE, 32'hFFFF_FFFF);
        write_reg(srte_pkg::REG_CELL_LOG, 32'd23);
        write_reg(srte_pkg::REG_OVERHEAD, 32'hFF);
        write_reg(srte_pkg::REG_MIN_PKT, 32'hFF);
        write_reg(srte_pkg::REG_TICK_FACTOR, 32'hFFFF_FFFF);
        close_writes();
        send_request(8'd0);
        send_request(8'd255);
        wait_drained();

        // exponent above 23 clamps; upper data bits ignored
        write_reg(srte_pkg::REG_RATE, 32'd1_000_000_000);
        write_reg(srte_pkg::REG_CELL_LOG, 32'hFFFF_FFDE);
        write_reg(srte_pkg::REG_TICK_FACTOR, 32'h0001_0000);
        close_writes();
        send_request(8'd255);
        send_request(8'd1);
        wait_drained();

        // most negative exponent selects auto; largest and smallest mtu
        write_reg(srte_pkg::REG_CELL_LOG, 32'h20);
        write_reg(srte_pkg::REG_MTU, 32'hFFFF);
        write_reg(srte_pkg::REG_OVERHEAD, 32'd0);
        write_reg(srte_pkg::REG_MIN_PKT, 32'd0);
        close_writes();
        send_request(8'd255);
        send_request(8'd0);
        wait_drained();
        write_reg(srte_pkg::REG_MTU, 32'd1);
        close_writes();
        send_request(8'd255);
        send_request(8'd0);
        wait_drained();

        // zero tick factor gives zero ticks without saturation
        write_reg(srte_pkg::REG_RATE, 32'd1);
        write_reg(srte_pkg::REG_TICK_FACTOR, 32'd0);
        close_writes();
        send_request(8'd255);
        send_request(8'd3);
        wait_drained();

        // huge microsecond count: high partial product overflows
        write_reg(srte_pkg::REG_CELL_LOG, 32'd23);
        write_reg(srte_pkg::REG_TICK_FACTOR, 32'hFFFF_FFFF);
        close_writes();
        send_request(8'd255);
        send_request(8'd0);
        wait_drained();

        // writes to unused indexes must not disturb any register
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'h0000_0000);
        close_writes();
        send_request(8'd7);
        wait_drained();

        // minimum packet size raises small cells
        write_reg(srte_pkg::REG_RATE, 32'd1000);
        write_reg(srte_pkg::REG_CELL_LOG, 32'd0);
        write_reg(srte_pkg::REG_MIN_PKT, 32'd200);
        write_reg(srte_pkg::REG_OVERHEAD, 32'd3);
        write_reg(srte_pkg::REG_TICK_FACTOR, 32'h0001_0000);
        close_writes();
        send_request(8'd2);
        send_request(8'd250);
        wait_drained();

        // --- random phases: no idling, sender idle 67 of 100, then 28 of 100 ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_config();
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 67;
                default: idle_pct = 28;
            endcase
            count = $urandom_range(80, 60);
            for (int i = 0; i < count; i++) begin
                // once, let the pipeline run dry in the middle of a phase
                if (phase == 1 && i == count / 2)
                    wait_drained();
                if ($urandom_range(99) < idle_pct) begin
                    start <= 1'b0;
                    @(posedge clk);
                    while ($urandom_range(99) < idle_pct)
                        @(posedge clk);
                end
                send_request(8'($urandom_range(255)));
            end
            wait_drained();
        end

        // tail: nothing more may come out
        repeat (RESULT_LATENCY + 8) @(posedge clk);
        if (entry_check.mismatches == 0 && entry_check.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
